>>> rtl/core/section_slot_allocator_unit_defines.svh
// Assertion macros of the port-level checker of the section slot allocator.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef SECTION_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define SECTION_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSA_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ssa_pkg.sv
// Shared types and constants of the section slot allocator.
// Depends on nothing; imported by every module of the block.
package ssa_pkg;

   localparam int NUM_SECTIONS_DEF  = 1024;
   localparam int SECTION_SHIFT_DEF = 20;

   localparam int ADDR_W         = 32;
   localparam int IO_FIRST_W     = 11;
   localparam int SEARCH_START_W = 10;
   localparam int CSR_DATA_W     = 11;
   localparam int CSR_IDX_W      = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IO_FIRST_SLOT     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_START_SLOT = 1'b1;

   localparam logic [IO_FIRST_W-1:0]     IO_FIRST_RESET     = 11'd1008;
   localparam logic [SEARCH_START_W-1:0] SEARCH_START_RESET = 10'd10;

   typedef enum logic [1:0] {
      FUNC_INIT  = 2'd0,
      FUNC_ALLOC = 2'd1,
      FUNC_FREE  = 2'd2,
      FUNC_QUERY = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_VACANT   = 2'd0,
      KIND_OCCUPIED = 2'd1,
      KIND_IO       = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] phys_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] section_base;
      status_type        status;
      kind_type          slot_kind;
   } rsp_type;

   // Scan pointer operations.
   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_IO_FIRST,
      PTR_SEARCH_START,
      PTR_INC
   } ptr_op_type;

   typedef enum logic [1:0] {
      WADDR_PTR,
      WADDR_ZERO,
      WADDR_SEC
   } waddr_sel_type;

   typedef enum logic {
      RADDR_PTR,
      RADDR_SEC
   } raddr_sel_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_DONE,
      RSP_ALLOC,
      RSP_FULL,
      RSP_RANGE,
      RSP_QUERY
   } rsp_op_type;

   typedef struct packed {
      ptr_op_type    ptr_op;
      logic          addr_load;
      logic          mem_we;
      waddr_sel_type waddr_sel;
      kind_type      wkind;
      logic          mem_re;
      raddr_sel_type raddr_sel;
      rsp_op_type    rsp_op;
   } cmd_type;

   typedef struct packed {
      logic ptr_end;
      logic rd_vacant;
      logic sec_in_range;
   } stat_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT_IO,
      ST_ALLOC_RD,
      ST_ALLOC_CHK,
      ST_FREE,
      ST_QUERY_RD,
      ST_QUERY_WAIT
   } state_type;

endpackage

>>> rtl/core/section_slot_allocator_unit.sv
// Top level of the section slot allocator: first-fit allocation over a table
// of physical memory sections. Depends on ssa_pkg, ssa_controller, ssa_datapath.
//
//   Channel   Ports                                 Handshake
//   request   start, busy, req_item                 taken when start && !busy
//   result    rsp_valid, rsp_item                   one-cycle strobe, no stall
//   config    csr_we, csr_index, csr_wdata          written when csr_we is high
//
// The block handles one item at a time; busy stays high from acceptance until
// the cycle in which the result strobe is shown, and a new item may be
// accepted in that very cycle. The first-fit scan reads a table entry in
// ST_ALLOC_RD and checks it in ST_ALLOC_CHK, and init writes one entry per
// cycle from the IO start up to the table end.
//
// After reset a clearing pass writes every table entry vacant, one entry per
// cycle, and busy stays high until that pass is over. Configuration writes
// are taken during this pass as at any other time. The receiver of results
// cannot stall the block.
module section_slot_allocator_unit #(
   parameter int NUM_SECTIONS  = ssa_pkg::NUM_SECTIONS_DEF,
   parameter int SECTION_SHIFT = ssa_pkg::SECTION_SHIFT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ssa_pkg::req_type                    req_item,
   output logic                                rsp_valid,
   output ssa_pkg::rsp_type                    rsp_item,
   input  logic                                csr_we,
   input  logic [ssa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ssa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ssa_pkg::*;

   // Commands from the controller and status back from the datapath.
   cmd_type  cmd;
   stat_type stat;

   // The controller sequences every operation: the clearing pass, the init
   // sweep, the first-fit scan, and the single-entry free and query.
   ssa_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_item.func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The datapath owns the kind table, the scan pointer, the latched address,
   // the configuration registers and the registered result.
   ssa_datapath #(
      .NUM_SECTIONS  (NUM_SECTIONS),
      .SECTION_SHIFT (SECTION_SHIFT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

>>> rtl/core/ssa_datapath.sv
// Datapath of the section slot allocator: kind table, scan pointer,
// configuration registers and result register. Depends on ssa_pkg.
module ssa_datapath #(
   parameter int NUM_SECTIONS  = ssa_pkg::NUM_SECTIONS_DEF,
   parameter int SECTION_SHIFT = ssa_pkg::SECTION_SHIFT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ssa_pkg::req_type                    req_item,
   input  logic                                csr_we,
   input  logic [ssa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ssa_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  ssa_pkg::cmd_type                    cmd,
   output ssa_pkg::stat_type                   stat,
   output logic                                rsp_valid,
   output ssa_pkg::rsp_type                    rsp_item
);
   import ssa_pkg::*;

   localparam int IDX_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
   localparam int CNT_W = $clog2(NUM_SECTIONS + 1);
   localparam int PTR_W = (CNT_W > IO_FIRST_W) ? CNT_W : IO_FIRST_W;

   logic [IO_FIRST_W-1:0]     io_first_ff;
   logic [SEARCH_START_W-1:0] search_start_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic [PTR_W-1:0]          ptr_ff;
   logic [PTR_W-1:0]          ptr_in;
   kind_type                  rd_kind_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [ADDR_W-1:0]         sec_full;
   logic [IDX_W-1:0]          sec_idx;
   logic [IDX_W-1:0]          ptr_idx;
   logic [IDX_W-1:0]          waddr;
   logic [IDX_W-1:0]          raddr;

   kind_type kinds_mem [NUM_SECTIONS];

   assign sec_full = addr_ff >> SECTION_SHIFT;
   assign sec_idx  = sec_full[IDX_W-1:0];
   assign ptr_idx  = ptr_ff[IDX_W-1:0];

   assign stat.sec_in_range = (sec_full < ADDR_W'(NUM_SECTIONS));
   assign stat.ptr_end      = (ptr_ff >= PTR_W'(NUM_SECTIONS));
   assign stat.rd_vacant    = (rd_kind_ff == KIND_VACANT);

   always_comb begin
      unique case (cmd.waddr_sel)
         WADDR_PTR:  waddr = ptr_idx;
         WADDR_ZERO: waddr = '0;
         WADDR_SEC:  waddr = sec_idx;
         default:    waddr = ptr_idx;
      endcase
      unique case (cmd.raddr_sel)
         RADDR_PTR: raddr = ptr_idx;
         RADDR_SEC: raddr = sec_idx;
         default:   raddr = ptr_idx;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         kinds_mem[waddr] <= cmd.wkind;
      end
      if (cmd.mem_re) begin
         rd_kind_ff <= kinds_mem[raddr];
      end
   end

   always_comb begin
      unique case (cmd.ptr_op)
         PTR_HOLD:         ptr_in = ptr_ff;
         PTR_IO_FIRST:     ptr_in = PTR_W'(io_first_ff);
         PTR_SEARCH_START: ptr_in = PTR_W'(search_start_ff);
         PTR_INC:          ptr_in = ptr_ff + PTR_W'(1);
         default:          ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.addr_load) begin
         addr_ff <= req_item.phys_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         io_first_ff     <= IO_FIRST_RESET;
         search_start_ff <= SEARCH_START_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IO_FIRST_SLOT:     io_first_ff     <= csr_wdata[IO_FIRST_W-1:0];
            CSR_SEARCH_START_SLOT: search_start_ff <= csr_wdata[SEARCH_START_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      case (cmd.rsp_op)
         RSP_DONE: begin
            rsp_in.section_base = '0;
            rsp_in.status       = STATUS_OK;
            rsp_in.slot_kind    = KIND_VACANT;
         end
         RSP_ALLOC: begin
            rsp_in.section_base = ADDR_W'(ptr_ff) << SECTION_SHIFT;
            rsp_in.status       = STATUS_OK;
            rsp_in.slot_kind    = KIND_OCCUPIED;
         end
         RSP_FULL: begin
            rsp_in.section_base = '0;
            rsp_in.status       = STATUS_FULL;
            rsp_in.slot_kind    = KIND_VACANT;
         end
         RSP_RANGE: begin
            rsp_in.section_base = '0;
            rsp_in.status       = STATUS_RANGE;
            rsp_in.slot_kind    = KIND_VACANT;
         end
         RSP_QUERY: begin
            rsp_in.section_base = '0;
            rsp_in.status       = STATUS_OK;
            rsp_in.slot_kind    = rd_kind_ff;
         end
         default: rsp_in = rsp_ff;
      endcase
   end

   assign rsp_valid_in = (cmd.rsp_op != RSP_NONE);

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> rtl/core/ssa_controller.sv
// Controller state machine of the section slot allocator.
// Depends on ssa_pkg; drives the datapath by command and status structs.
module ssa_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ssa_pkg::func_type req_func,
   input  ssa_pkg::stat_type stat,
   output ssa_pkg::cmd_type  cmd,
   output logic              busy
);
   import ssa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.ptr_op    = PTR_HOLD;
      cmd.addr_load = 1'b0;
      cmd.mem_we    = 1'b0;
      cmd.waddr_sel = WADDR_PTR;
      cmd.wkind     = KIND_VACANT;
      cmd.mem_re    = 1'b0;
      cmd.raddr_sel = RADDR_PTR;
      cmd.rsp_op    = RSP_NONE;

      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.ptr_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mem_we = 1'b1;
               cmd.ptr_op = PTR_INC;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.addr_load = 1'b1;
               unique case (req_func)
                  FUNC_INIT: begin
                     cmd.mem_we    = 1'b1;
                     cmd.waddr_sel = WADDR_ZERO;
                     cmd.wkind     = KIND_OCCUPIED;
                     cmd.ptr_op    = PTR_IO_FIRST;
                     state_in      = ST_INIT_IO;
                  end
                  FUNC_ALLOC: begin
                     cmd.ptr_op = PTR_SEARCH_START;
                     state_in   = ST_ALLOC_RD;
                  end
                  FUNC_FREE:  state_in = ST_FREE;
                  FUNC_QUERY: state_in = ST_QUERY_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT_IO: begin
            if (stat.ptr_end) begin
               cmd.rsp_op = RSP_DONE;
               state_in   = ST_IDLE;
            end else begin
               cmd.mem_we = 1'b1;
               cmd.wkind  = KIND_IO;
               cmd.ptr_op = PTR_INC;
            end
         end
         ST_ALLOC_RD: begin
            if (stat.ptr_end) begin
               cmd.rsp_op = RSP_FULL;
               state_in   = ST_IDLE;
            end else begin
               cmd.mem_re = 1'b1;
               state_in   = ST_ALLOC_CHK;
            end
         end
         ST_ALLOC_CHK: begin
            if (stat.rd_vacant) begin
               cmd.mem_we = 1'b1;
               cmd.wkind  = KIND_OCCUPIED;
               cmd.rsp_op = RSP_ALLOC;
               state_in   = ST_IDLE;
            end else begin
               cmd.ptr_op = PTR_INC;
               state_in   = ST_ALLOC_RD;
            end
         end
         ST_FREE: begin
            if (stat.sec_in_range) begin
               cmd.mem_we    = 1'b1;
               cmd.waddr_sel = WADDR_SEC;
               cmd.rsp_op    = RSP_DONE;
            end else begin
               cmd.rsp_op = RSP_RANGE;
            end
            state_in = ST_IDLE;
         end
         ST_QUERY_RD: begin
            if (stat.sec_in_range) begin
               cmd.mem_re    = 1'b1;
               cmd.raddr_sel = RADDR_SEC;
               state_in      = ST_QUERY_WAIT;
            end else begin
               cmd.rsp_op = RSP_RANGE;
               state_in   = ST_IDLE;
            end
         end
         ST_QUERY_WAIT: begin
            cmd.rsp_op = RSP_QUERY;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> rtl/core/ssa_checker.sv
// Port-level checks of the section slot allocator, bound to its top level.
// Depends on ssa_pkg and section_slot_allocator_unit_defines.svh.
`include "section_slot_allocator_unit_defines.svh"

module ssa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input ssa_pkg::rsp_type rsp_item
);
   import ssa_pkg::*;

   `SSA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted item did not raise busy")
   `SSA_ASSERT_HOLDS(a_rsp_idle, clock, reset, rsp_valid, !busy, "result shown while still busy")
   `SSA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "two results in a row")
   `SSA_ASSERT_HOLDS(a_fail_clean, clock, reset, rsp_valid && (rsp_item.status != STATUS_OK), (rsp_item.section_base == '0) && (rsp_item.slot_kind == KIND_VACANT), "failed result carries data")

endmodule

bind section_slot_allocator_unit ssa_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

>>> verif/section_slot_allocator_unit_checker.sv
// Result checker of the section slot allocator: keeps its own section table,
// predicts the result of every accepted item and compares it with the block.
// Depends on ssa_pkg for the item, result and register encodings.
module section_slot_allocator_unit_checker #(
   parameter int NUM_SECTIONS  = ssa_pkg::NUM_SECTIONS_DEF,
   parameter int SECTION_SHIFT = ssa_pkg::SECTION_SHIFT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  ssa_pkg::req_type               req_item,
   input  logic                           rsp_valid,
   input  ssa_pkg::rsp_type               rsp_item,
   input  logic                           csr_we,
   input  logic [ssa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    fail_count,
   output int unsigned                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ssa_pkg::*;

   kind_type                  kind_table [NUM_SECTIONS];
   logic [IO_FIRST_W-1:0]     io_first;
   logic [SEARCH_START_W-1:0] search_start;
   rsp_type                   awaited_results [$];
   int unsigned               mismatches = 0;

   // Applies one item to the shadow table and returns the result it must give.
   function automatic rsp_type apply_section_op(req_type item);
      rsp_type     res;
      int unsigned sec;
      int unsigned k;
      bit          found;
      res.section_base = '0;
      res.status       = STATUS_OK;
      res.slot_kind    = KIND_VACANT;
      sec   = item.phys_address >> SECTION_SHIFT;
      found = 1'b0;
      case (item.func)
         FUNC_INIT: begin
            // Section 0 goes occupied first, so an IO start of zero overrides it.
            kind_table[0] = KIND_OCCUPIED;
            for (k = io_first; k < NUM_SECTIONS; k++)
               kind_table[k] = KIND_IO;
         end
         FUNC_ALLOC: begin
            for (k = search_start; k < NUM_SECTIONS && !found; k++) begin
               if (kind_table[k] == KIND_VACANT) begin
                  kind_table[k]    = KIND_OCCUPIED;
                  res.section_base = ADDR_W'(k << SECTION_SHIFT);
                  res.slot_kind    = KIND_OCCUPIED;
                  found            = 1'b1;
               end
            end
            if (!found)
               res.status = STATUS_FULL;
         end
         default: begin
            if (sec >= NUM_SECTIONS)
               res.status = STATUS_RANGE;
            else if (item.func == FUNC_FREE)
               kind_table[sec] = KIND_VACANT;
            else
               res.slot_kind = kind_table[sec];
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      int      k;
      if (reset) begin
         for (k = 0; k < NUM_SECTIONS; k++)
            kind_table[k] = KIND_VACANT;
         io_first     = IO_FIRST_RESET;
         search_start = SEARCH_START_RESET;
         awaited_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IO_FIRST_SLOT:     io_first     = csr_wdata[IO_FIRST_W-1:0];
               CSR_SEARCH_START_SLOT: search_start = csr_wdata[SEARCH_START_W-1:0];
            endcase
         end
         // A result belongs to an earlier item, so it is retired before a new
         // item accepted at the same edge is predicted.
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result: base %h status %0d kind %0d",
                        $time, rsp_item.section_base, rsp_item.status,
                        rsp_item.slot_kind);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_item.section_base !== want.section_base ||
                   rsp_item.status !== want.status ||
                   rsp_item.slot_kind !== want.slot_kind) begin
                  $display({"%0t: expected base %h status %0d kind %0d, ",
                            "got base %h status %0d kind %0d"},
                           $time, want.section_base, want.status, want.slot_kind,
                           rsp_item.section_base, rsp_item.status, rsp_item.slot_kind);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            awaited_results.push_back(apply_section_op(req_item));
      end
      fail_count    <= mismatches;
      pending_count <= awaited_results.size();
   end

endmodule

>>> verif/section_slot_allocator_unit_tb.sv
// Testbench top of the section slot allocator: drives items and register
// writes, and gives the verdict. Depends on ssa_pkg, the block and its checker.
module section_slot_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssa_pkg::*;

   localparam int NUM_SECTIONS  = NUM_SECTIONS_DEF;
   localparam int SECTION_SHIFT = SECTION_SHIFT_DEF;

   // Frees and queries mostly land in a window just above the search start,
   // so allocations keep finding holes close by and scans stay short.
   localparam int WINDOW      = 40;
   localparam int MAX_GAP     = 17;
   localparam int PHASE_ITEMS = 68;

   // The longest result is an allocate that scans the whole table and finds
   // nothing. Once all items are in, a drain of that scan's length with a small
   // margin is enough to catch a stray late result.
   localparam int DRAIN_CYCLES = 2 * NUM_SECTIONS + 4;

   // Slowest correct run: about 600 items, each waiting the longest gap and
   // then a full failed scan, plus the clearing pass after reset. The limit
   // is about four times that.
   localparam int CYCLE_LIMIT = 5_000_000;

   localparam logic [ADDR_W-1:0] OFFSET_MASK = {ADDR_W{1'b1}} >> (ADDR_W - SECTION_SHIFT);

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   req_type               req_item  = '0;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  busy;
   logic                  rsp_valid;
   rsp_type               rsp_item;

   int unsigned slot_failures;
   int unsigned slot_outstanding;
   int unsigned cycle_count = 0;

   // When set, the sender offers the next item right away, so back-to-back
   // stretches appear between the randomly idled ones.
   bit steady_sender = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   section_slot_allocator_unit #(
      .NUM_SECTIONS  (NUM_SECTIONS),
      .SECTION_SHIFT (SECTION_SHIFT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   section_slot_allocator_unit_checker #(
      .NUM_SECTIONS  (NUM_SECTIONS),
      .SECTION_SHIFT (SECTION_SHIFT)
   ) slot_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (slot_failures),
      .pending_count (slot_outstanding)
   );

   function automatic logic [ADDR_W-1:0] section_addr(int unsigned sec);
      return ADDR_W'(sec) << SECTION_SHIFT;
   endfunction

   // A byte address for a free or a query: some point outside the table, some
   // anywhere in it, most into the window. The offset bits are always random.
   function automatic logic [ADDR_W-1:0] pick_address(int unsigned win_base);
      int unsigned pick;
      int unsigned sec;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         sec = $urandom_range(NUM_SECTIONS, (1 << (ADDR_W - SECTION_SHIFT)) - 1);
      else if (pick < 24)
         sec = $urandom_range(0, NUM_SECTIONS - 1);
      else
         sec = win_base + $urandom_range(0, WINDOW - 1);
      return section_addr(sec) | (ADDR_W'($urandom()) & OFFSET_MASK);
   endfunction

   // Offers one item after a random pause, or none when steady_sender is set,
   // and returns at the edge that takes it. Start is left high, so a following
   // item with no pause keeps it high instead of toggling it within one time step.
   task automatic issue(input func_type op, input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = steady_sender ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= '{func: op, phys_address: addr};
      do @(posedge clock); while (busy);
   endtask

   // Holds the sender off until every predicted result has come back. The
   // first edge lets the checker count the item taken at the calling edge.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (slot_outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the IO start, then the search start. The unused top bit of
   // the search start write is random; the block must ignore it.
   task automatic program_slots(input logic [IO_FIRST_W-1:0]     io_first,
                                input logic [SEARCH_START_W-1:0] search_start);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom());
      data[SEARCH_START_W-1:0] = search_start;
      csr_we    <= 1'b1;
      csr_index <= CSR_IO_FIRST_SLOT;
      csr_wdata <= CSR_DATA_W'(io_first);
      @(posedge clock);
      csr_index <= CSR_SEARCH_START_SLOT;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One random phase under one register setting. It opens with an init and a
   // query of section 0, then mixes allocates, frees and queries, with an
   // occasional init. Alloc and init items carry random, unused addresses.
   task automatic run_phase(input logic [IO_FIRST_W-1:0]     io_first,
                            input logic [SEARCH_START_W-1:0] search_start,
                            input bit                        steady);
      int unsigned win_base;
      int unsigned pick;
      int          n;
      func_type    op;
      settle();
      program_slots(io_first, search_start);
      steady_sender = steady;
      win_base = (search_start + WINDOW <= NUM_SECTIONS) ? search_start
                                                         : NUM_SECTIONS - WINDOW;
      issue(FUNC_INIT, $urandom());
      issue(FUNC_QUERY, ADDR_W'($urandom()) & OFFSET_MASK);
      for (n = 0; n < PHASE_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         op = (pick < 3)  ? FUNC_INIT :
              (pick < 43) ? FUNC_ALLOC :
              (pick < 73) ? FUNC_FREE : FUNC_QUERY;
         if (op == FUNC_FREE || op == FUNC_QUERY)
            issue(op, pick_address(win_base));
         else
            issue(op, $urandom());
      end
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // The block clears its table after reset and stays busy meanwhile.
      do @(posedge clock); while (busy);

      // Directed part under the reset settings: the table before any init,
      // a plain allocate, free and query, and both edges of the table range.
      issue(FUNC_QUERY, section_addr(0));
      issue(FUNC_ALLOC, 32'h0000_0000);
      issue(FUNC_QUERY, section_addr(10) | OFFSET_MASK);
      issue(FUNC_FREE, section_addr(10));
      issue(FUNC_QUERY, section_addr(10));
      issue(FUNC_FREE, 32'hFFFF_FFFF);
      issue(FUNC_QUERY, section_addr(NUM_SECTIONS));
      issue(FUNC_QUERY, section_addr(NUM_SECTIONS) - 1);
      issue(FUNC_INIT, 32'hFFFF_FFFF);
      issue(FUNC_QUERY, section_addr(0));
      issue(FUNC_QUERY, section_addr(1008));
      issue(FUNC_QUERY, section_addr(1007));
      issue(FUNC_ALLOC, 32'hFFFF_FFFF);
      issue(FUNC_ALLOC, 32'h0000_0000);

      // Search starting at the last section, which init made IO: the table
      // looks full until that section is freed, then it is handed out.
      settle();
      program_slots(IO_FIRST_RESET, SEARCH_START_W'(NUM_SECTIONS - 1));
      issue(FUNC_ALLOC, 32'h0000_0000);
      issue(FUNC_FREE, section_addr(NUM_SECTIONS - 1));
      issue(FUNC_ALLOC, 32'h0000_0000);
      issue(FUNC_ALLOC, 32'h0000_0000);

      // An IO start past the table end marks no section IO; exactly at the end too.
      settle();
      program_slots({IO_FIRST_W{1'b1}}, 10'd1000);
      issue(FUNC_INIT, 32'h0000_0000);
      issue(FUNC_QUERY, section_addr(NUM_SECTIONS - 1));
      settle();
      program_slots(IO_FIRST_W'(NUM_SECTIONS), 10'd1000);
      issue(FUNC_INIT, 32'h0000_0000);

      // Only two vacant sections remain below the IO region: the third
      // allocate runs into the table end.
      settle();
      program_slots(11'd1002, 10'd1000);
      issue(FUNC_INIT, 32'h0000_0000);
      issue(FUNC_ALLOC, 32'h0000_0000);
      issue(FUNC_ALLOC, 32'h0000_0000);
      issue(FUNC_ALLOC, 32'h0000_0000);

      // Random phases. Early ones keep the IO region high so that scans stay
      // short; the search start extremes come in the second and fourth, the
      // near-full end of the table in the seventh. The last one moves the IO
      // start to zero, so every section turns IO and only freed ones can be
      // allocated again. The second phase never idles the sender.
      run_phase(11'd1008, 10'd10, $urandom_range(0, 3) == 0);
      run_phase({IO_FIRST_W{1'b1}}, 10'd0, 1'b1);
      run_phase(IO_FIRST_W'(NUM_SECTIONS), 10'd512, $urandom_range(0, 3) == 0);
      run_phase(11'd950, {SEARCH_START_W{1'b1}}, $urandom_range(0, 3) == 0);
      run_phase(11'd1000, 10'd300, $urandom_range(0, 3) == 0);
      run_phase(11'd1535, 10'd700, $urandom_range(0, 3) == 0);
      run_phase(11'd1010, 10'd980, $urandom_range(0, 3) == 0);
      run_phase('0, 10'd0, $urandom_range(0, 3) == 0);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (slot_failures == 0)
         $display("section_slot_allocator_unit test passed");
      else
         $display("section_slot_allocator_unit test failed");
      $finish;
   end

   // Watchdog: a lost result or a block stuck busy ends the run here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("section_slot_allocator_unit test failed");
      $finish;
   end

endmodule
